[rtl/core/i2a_pkg.sv]
// Package for the integer to ASCII radix converter.
// Holds request/result types, controller states, phase codes and the character helpers.
// No dependencies.
`timescale 1ns / 1ps

package i2a_pkg;

  localparam int MAX_CHARS = 64;
  localparam int CNT_W     = ($clog2(MAX_CHARS + 1) > 7) ? $clog2(MAX_CHARS + 1) : 7;
  localparam int VAL_W     = 32;
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = VAL_W / DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ALPHA = 8'h41;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NONE  = 8'h00;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  radix;
    logic        treat_signed;
    logic [5:0]  zero_width;
    logic [6:0]  space_width;
  } req_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
    logic [6:0] total_length;
    logic       bad_radix;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BAD,
    ST_DIV,
    ST_DIGIT,
    ST_ZERO,
    ST_SIGN,
    ST_SPACE
  } state_e;

  typedef enum logic [2:0] {
    PH_DIGIT,
    PH_ZERO,
    PH_SIGN,
    PH_SPACE,
    PH_DONE
  } phase_e;

  typedef struct packed {
    logic   load;
    logic   div_step;
    logic   emit;
    phase_e emit_phase;
    logic   bad;
  } cmd_t;

  typedef struct packed {
    logic   req_bad;
    logic   req_nz;
    logic   div_done;
    phase_e next_phase;
  } stat_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    logic [7:0] c;
    if (d < 6'd10) begin
      c = CH_ZERO + {2'b00, d};
    end else begin
      c = CH_ALPHA + {2'b00, d} - 8'd10;
    end
    return c;
  endfunction

  function automatic phase_e next_phase(input phase_e           from,
                                        input logic             mag_nz,
                                        input logic [CNT_W-1:0] n1,
                                        input logic [CNT_W-1:0] zw,
                                        input logic             neg,
                                        input logic [CNT_W-1:0] sw);
    phase_e p;
    if (from == PH_DIGIT && mag_nz && n1 < CNT_W'(MAX_CHARS)) begin
      p = PH_DIGIT;
    end else if ((from == PH_DIGIT || from == PH_ZERO) && n1 < zw) begin
      p = PH_ZERO;
    end else if (from != PH_SPACE && neg && n1 < CNT_W'(MAX_CHARS)) begin
      p = PH_SIGN;
    end else if (n1 < sw) begin
      p = PH_SPACE;
    end else begin
      p = PH_DONE;
    end
    return p;
  endfunction

endpackage

[rtl/core/i2a_ctrl.sv]
// Controller state machine of the integer to ASCII radix converter.
// Sequences division, digit, padding and sign output and the bad-radix result; depends on i2a_pkg.
`timescale 1ns / 1ps

module i2a_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  i2a_pkg::stat_t  stat_i,
  output i2a_pkg::cmd_t   cmd_o,
  output logic            busy_o
);

  i2a_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2a_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      i2a_pkg::ST_IDLE: begin
        if (start_i) begin
          if (stat_i.req_bad) begin
            state_d = i2a_pkg::ST_BAD;
          end else if (stat_i.req_nz) begin
            state_d = i2a_pkg::ST_DIV;
          end else begin
            state_d = i2a_pkg::ST_ZERO;
          end
        end
      end
      i2a_pkg::ST_BAD: begin
        state_d = i2a_pkg::ST_IDLE;
      end
      i2a_pkg::ST_DIV: begin
        if (stat_i.div_done) begin
          state_d = i2a_pkg::ST_DIGIT;
        end
      end
      i2a_pkg::ST_DIGIT, i2a_pkg::ST_ZERO, i2a_pkg::ST_SIGN, i2a_pkg::ST_SPACE: begin
        case (stat_i.next_phase)
          i2a_pkg::PH_DIGIT: state_d = i2a_pkg::ST_DIV;
          i2a_pkg::PH_ZERO:  state_d = i2a_pkg::ST_ZERO;
          i2a_pkg::PH_SIGN:  state_d = i2a_pkg::ST_SIGN;
          i2a_pkg::PH_SPACE: state_d = i2a_pkg::ST_SPACE;
          default:           state_d = i2a_pkg::ST_IDLE;
        endcase
      end
      default: begin
        state_d = i2a_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.emit_phase = i2a_pkg::PH_DIGIT;
    busy_o           = 1'b1;
    case (state_q)
      i2a_pkg::ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      i2a_pkg::ST_BAD: begin
        cmd_o.bad = 1'b1;
      end
      i2a_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
      end
      i2a_pkg::ST_DIGIT: begin
        cmd_o.emit       = 1'b1;
        cmd_o.emit_phase = i2a_pkg::PH_DIGIT;
      end
      i2a_pkg::ST_ZERO: begin
        cmd_o.emit       = 1'b1;
        cmd_o.emit_phase = i2a_pkg::PH_ZERO;
      end
      i2a_pkg::ST_SIGN: begin
        cmd_o.emit       = 1'b1;
        cmd_o.emit_phase = i2a_pkg::PH_SIGN;
      end
      i2a_pkg::ST_SPACE: begin
        cmd_o.emit       = 1'b1;
        cmd_o.emit_phase = i2a_pkg::PH_SPACE;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

[rtl/core/i2a_datapath.sv]
// Datapath of the integer to ASCII radix converter: request registers, radix divider
// (four quotient bits per cycle), character counter and result register; depends on i2a_pkg.
`timescale 1ns / 1ps

module i2a_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  i2a_pkg::req_t  req_i,
  input  i2a_pkg::cmd_t  cmd_i,
  output i2a_pkg::stat_t stat_o,
  output logic           valid_o,
  output i2a_pkg::res_t  res_o
);

  logic [i2a_pkg::VAL_W-1:0]  mag_q, mag_d;
  logic [5:0]                 rem_q, rem_d;
  logic [5:0]                 radix_q;
  logic                       neg_q;
  logic [i2a_pkg::CNT_W-1:0]  zw_q, sw_q;
  logic [i2a_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [i2a_pkg::STEP_W-1:0] step_q, step_d;
  logic                       valid_q, valid_d;
  i2a_pkg::res_t              res_q, res_d;

  logic                       req_neg;
  logic [i2a_pkg::CNT_W-1:0]  zw_ext, zw_lim, zw_eff, sw_ext, sw_eff;
  logic [i2a_pkg::CNT_W-1:0]  cnt_inc;
  i2a_pkg::phase_e            from_phase, nxt;
  logic [7:0]                 emit_char;
  logic [6:0]                 trial;

  assign req_neg = req_i.treat_signed & req_i.value[i2a_pkg::VAL_W-1];

  always_comb begin
    zw_ext = i2a_pkg::CNT_W'(req_i.zero_width);
    if (zw_ext == '0) begin
      zw_ext = i2a_pkg::CNT_W'(1);
    end
    zw_lim = i2a_pkg::CNT_W'(i2a_pkg::MAX_CHARS) - i2a_pkg::CNT_W'(req_neg);
    zw_eff = (zw_ext > zw_lim) ? zw_lim : zw_ext;
    sw_ext = i2a_pkg::CNT_W'(req_i.space_width);
    sw_eff = (sw_ext > i2a_pkg::CNT_W'(i2a_pkg::MAX_CHARS)) ?
             i2a_pkg::CNT_W'(i2a_pkg::MAX_CHARS) : sw_ext;
  end

  assign stat_o.req_bad  = (req_i.radix < i2a_pkg::RADIX_MIN) ||
                           (req_i.radix > i2a_pkg::RADIX_MAX);
  assign stat_o.req_nz   = (req_i.value != '0);
  assign stat_o.div_done = cmd_i.div_step && (step_q == {i2a_pkg::STEP_W{1'b1}});

  assign cnt_inc    = cnt_q + i2a_pkg::CNT_W'(1);
  assign from_phase = (cmd_i.emit_phase == i2a_pkg::PH_SIGN) ? i2a_pkg::PH_SPACE
                                                               : cmd_i.emit_phase;
  assign nxt        = i2a_pkg::next_phase(from_phase, (mag_q != '0), cnt_inc,
                                          zw_q, neg_q, sw_q);
  assign stat_o.next_phase = nxt;

  always_comb begin
    case (cmd_i.emit_phase)
      i2a_pkg::PH_DIGIT: emit_char = i2a_pkg::digit_char(rem_q);
      i2a_pkg::PH_ZERO:  emit_char = i2a_pkg::CH_ZERO;
      i2a_pkg::PH_SIGN:  emit_char = i2a_pkg::CH_MINUS;
      default:           emit_char = i2a_pkg::CH_SPACE;
    endcase
  end

  always_comb begin
    mag_d  = mag_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    step_d = step_q;
    trial  = '0;
    if (cmd_i.load) begin
      mag_d  = req_neg ? (32'd0 - req_i.value) : req_i.value;
      rem_d  = '0;
      cnt_d  = '0;
      step_d = '0;
    end else if (cmd_i.div_step) begin
      for (int i = 0; i < i2a_pkg::DIV_BITS; i++) begin
        trial = {rem_d, mag_d[i2a_pkg::VAL_W-1]};
        mag_d = {mag_d[i2a_pkg::VAL_W-2:0], 1'b0};
        if (trial >= {1'b0, radix_q}) begin
          trial    = trial - {1'b0, radix_q};
          mag_d[0] = 1'b1;
        end
        rem_d = trial[5:0];
      end
      step_d = step_q + i2a_pkg::STEP_W'(1);
    end else if (cmd_i.emit) begin
      rem_d = '0;
      cnt_d = cnt_inc;
    end
  end

  always_comb begin
    valid_d = cmd_i.emit | cmd_i.bad;
    res_d   = res_q;
    if (cmd_i.bad) begin
      res_d.char_code    = i2a_pkg::CH_NONE;
      res_d.last         = 1'b1;
      res_d.total_length = '0;
      res_d.bad_radix    = 1'b1;
    end else if (cmd_i.emit) begin
      res_d.char_code    = emit_char;
      res_d.last         = (nxt == i2a_pkg::PH_DONE);
      res_d.total_length = (nxt == i2a_pkg::PH_DONE) ? cnt_inc[6:0] : 7'd0;
      res_d.bad_radix    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
      step_q  <= '0;
    end else begin
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    res_q <= res_d;
    if (cmd_i.load) begin
      radix_q <= req_i.radix;
      neg_q   <= req_neg;
      zw_q    <= zw_eff;
      sw_q    <= sw_eff;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

[rtl/core/integer_to_ascii_radix.sv]
// Top level of the integer to ASCII radix converter.
// Joins i2a_ctrl and i2a_datapath; depends on i2a_pkg.
//
// Usage:
//   A request (req_i) is taken at a rising edge with start_i high and busy_o low.
//   Characters leave least significant first on res_o, one per cycle that valid_o
//   is high; the final one has last set and carries total_length. A radix outside
//   2..36 yields a single result with bad_radix set and no character.
// Timing:
//   Each digit is computed by the radix divider, which retires four quotient bits
//   per cycle, and is then issued from the digit state. Each zero, sign or space
//   character is issued from its own state, and a bad radix from the bad state.
//   Each character shows on the ports in the cycle after it is issued, from the
//   result register; busy_o stays high until the last one is issued.
//   A new request may start as soon as busy_o is low.
// Reset:
//   rst_ni clears the controller and the result strobe; no request is pending.
//   Results cannot be held off: each is presented for exactly one cycle.
`timescale 1ns / 1ps

module integer_to_ascii_radix (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  i2a_pkg::req_t req_i,
  output logic          busy_o,
  output logic          valid_o,
  output i2a_pkg::res_t res_o
);

  i2a_pkg::cmd_t  cmd;
  i2a_pkg::stat_t stat;

  i2a_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  i2a_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .valid_o(valid_o),
    .res_o  (res_o)
  );

endmodule
